[rtl/core/sucbc_pkg.sv]
`timescale 1ns / 1ps
// package: widths, item types and the division step for the segment unit box clip
package sucbc_pkg;

   localparam int BlockW   = 16;
   localparam int CoordW   = 24;
   localparam int FracW    = 17;
   localparam int DistW    = 25;
   localparam int WideW    = 26;
   localparam int QuoW     = 18;
   localparam int DivSteps = QuoW;
   localparam int NumAxes  = 3;
   localparam int ProdW    = 43;

   localparam logic [QuoW-1:0] QuoOne = 18'h10000;

   typedef struct packed {
      logic [DistW-1:0] rem;
      logic [QuoW-1:0]  low;
      logic [QuoW-1:0]  quo;
   } div_lane_type;

   typedef struct packed {
      logic signed [CoordW-1:0] start;
      logic signed [DistW-1:0]  delta;
      logic [DistW-1:0]         divisor;
      logic                     parallel;
      logic                     par_miss;
      logic                     out_neg;
      div_lane_type             near;
      div_lane_type             far;
   } axis_type;

   typedef struct packed {
      axis_type [NumAxes-1:0] ax;
      logic [FracW-1:0]       best;
   } item_type;

   // one restoring division step, one quotient bit
   function automatic div_lane_type div_step(div_lane_type lane, logic [DistW-1:0] divisor);
      logic [DistW:0] trial;
      logic [DistW:0] diff;
      logic           ge;
      div_lane_type   res;
      trial    = {lane.rem, lane.low[QuoW-1]};
      diff     = trial - {1'b0, divisor};
      ge       = trial >= {1'b0, divisor};
      res.rem  = ge ? diff[DistW-1:0] : trial[DistW-1:0];
      res.low  = {lane.low[QuoW-2:0], 1'b0};
      res.quo  = {lane.quo[QuoW-2:0], ge};
      return res;
   endfunction

endpackage

[rtl/core/sucbc_prep.sv]
`timescale 1ns / 1ps
// input stage: slab faces, direction, near and far distances per axis
module sucbc_prep (
   input  logic                                             clock,
   input  logic                                             reset,
   input  logic                                             in_valid,
   output logic                                             in_stall,
   input  logic [sucbc_pkg::NumAxes-1:0][sucbc_pkg::BlockW-1:0] block,
   input  logic [sucbc_pkg::NumAxes-1:0][sucbc_pkg::CoordW-1:0] start,
   input  logic [sucbc_pkg::NumAxes-1:0][sucbc_pkg::CoordW-1:0] stop,
   input  logic [sucbc_pkg::FracW-1:0]                      best,
   output logic                                             out_valid,
   output sucbc_pkg::item_type                              out_item,
   input  logic                                             out_stall
);

   logic                valid_ff;
   sucbc_pkg::item_type item_ff;
   sucbc_pkg::item_type item_in;

   always_comb begin
      logic signed [sucbc_pkg::BlockW:0]   blk_m1;
      logic signed [sucbc_pkg::WideW-1:0]  face_lo;
      logic signed [sucbc_pkg::WideW-1:0]  face_hi;
      logic signed [sucbc_pkg::WideW-1:0]  s;
      logic signed [sucbc_pkg::WideW-1:0]  e;
      logic signed [sucbc_pkg::WideW-1:0]  dpos;
      logic signed [sucbc_pkg::WideW-1:0]  dneg;
      logic signed [sucbc_pkg::WideW-1:0]  dist_w;
      logic signed [sucbc_pkg::WideW-1:0]  n_in;
      logic signed [sucbc_pkg::WideW-1:0]  n_out;
      logic signed [sucbc_pkg::WideW-1:0]  c_in;
      logic signed [sucbc_pkg::WideW-1:0]  c_out;
      logic                                pos;
      item_in      = '0;
      item_in.best = best;
      for (int a = 0; a < sucbc_pkg::NumAxes; a++) begin
         blk_m1  = {block[a][sucbc_pkg::BlockW-1], block[a]} - 17'sd1;
         face_lo = {blk_m1[sucbc_pkg::BlockW], blk_m1, 8'h80};
         face_hi = {{2{block[a][sucbc_pkg::BlockW-1]}}, block[a], 8'h80};
         s       = {{2{start[a][sucbc_pkg::CoordW-1]}}, start[a]};
         e       = {{2{stop[a][sucbc_pkg::CoordW-1]}}, stop[a]};
         dpos    = e - s;
         dneg    = s - e;
         pos     = !dpos[sucbc_pkg::WideW-1] && (dpos != '0);
         dist_w  = pos ? dpos : dneg;
         n_in    = pos ? face_lo - s : s - face_hi;
         n_out   = pos ? face_hi - s : s - face_lo;
         // near distance clamped to [0, dist + 1], far to [0, dist]
         if (n_in[sucbc_pkg::WideW-1] || n_in == '0) begin
            c_in = '0;
         end else if (n_in > dist_w) begin
            c_in = dist_w + 26'sd1;
         end else begin
            c_in = n_in;
         end
         if (n_out[sucbc_pkg::WideW-1]) begin
            c_out = '0;
         end else if (n_out > dist_w) begin
            c_out = dist_w;
         end else begin
            c_out = n_out;
         end
         item_in.ax[a].start    = start[a];
         item_in.ax[a].delta    = dpos[sucbc_pkg::DistW-1:0];
         item_in.ax[a].divisor  = dist_w[sucbc_pkg::DistW-1:0];
         item_in.ax[a].parallel = (dpos == '0);
         item_in.ax[a].par_miss = (s < face_lo) || (s > face_hi);
         item_in.ax[a].out_neg  = n_out[sucbc_pkg::WideW-1];
         item_in.ax[a].near.rem = {2'b00, c_in[sucbc_pkg::DistW-1:2]};
         item_in.ax[a].near.low = {c_in[1:0], 16'h0000};
         item_in.ax[a].near.quo = '0;
         item_in.ax[a].far.rem  = {2'b00, c_out[sucbc_pkg::DistW-1:2]};
         item_in.ax[a].far.low  = {c_out[1:0], 16'h0000};
         item_in.ax[a].far.quo  = '0;
      end
   end

   assign in_stall  = valid_ff && out_stall;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!in_stall) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!in_stall) begin
         item_ff <= item_in;
      end
   end

endmodule

[rtl/core/sucbc_cell.sv]
`timescale 1ns / 1ps
// division cell: one quotient bit for the near and far lanes of every axis
module sucbc_cell (
   input  logic                clock,
   input  logic                reset,
   input  logic                in_valid,
   output logic                in_stall,
   input  sucbc_pkg::item_type in_item,
   output logic                out_valid,
   output sucbc_pkg::item_type out_item,
   input  logic                out_stall
);

   logic                valid_ff;
   sucbc_pkg::item_type item_ff;
   sucbc_pkg::item_type item_in;

   always_comb begin
      item_in = in_item;
      for (int a = 0; a < sucbc_pkg::NumAxes; a++) begin
         item_in.ax[a].near = sucbc_pkg::div_step(in_item.ax[a].near,
                                                  in_item.ax[a].divisor);
         item_in.ax[a].far  = sucbc_pkg::div_step(in_item.ax[a].far,
                                                  in_item.ax[a].divisor);
      end
   end

   assign in_stall  = valid_ff && out_stall;
   assign out_valid = valid_ff;
   assign out_item  = item_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (!in_stall) begin
         valid_ff <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (!in_stall) begin
         item_ff <= item_in;
      end
   end

endmodule

[rtl/core/sucbc_clip.sv]
`timescale 1ns / 1ps
// interval clip over the axes, entry point multiply and output register
module sucbc_clip (
   input  logic                                                 clock,
   input  logic                                                 reset,
   input  logic                                                 in_valid,
   output logic                                                 in_stall,
   input  sucbc_pkg::item_type                                  in_item,
   output logic                                                 rsp_valid,
   input  logic                                                 rsp_stall,
   output logic                                                 rsp_hit,
   output logic [sucbc_pkg::NumAxes-1:0][sucbc_pkg::CoordW-1:0] rsp_point,
   output logic [sucbc_pkg::FracW-1:0]                          rsp_entry_fraction,
   output logic [sucbc_pkg::FracW-1:0]                          rsp_best_fraction
);

   logic                                                 a_valid_ff;
   logic                                                 a_hit_ff;
   logic [sucbc_pkg::FracW-1:0]                          a_lo_ff;
   logic [sucbc_pkg::FracW-1:0]                          a_best_ff;
   logic [sucbc_pkg::NumAxes-1:0][sucbc_pkg::CoordW-1:0] a_start_ff;
   logic [sucbc_pkg::NumAxes-1:0][sucbc_pkg::DistW-1:0]  a_delta_ff;
   logic                                                 a_hit_in;
   logic [sucbc_pkg::QuoW-1:0]                           a_lo_in;

   logic                                                 b_valid_ff;
   logic                                                 b_hit_ff;
   logic [sucbc_pkg::FracW-1:0]                          b_lo_ff;
   logic [sucbc_pkg::FracW-1:0]                          b_best_ff;
   logic [sucbc_pkg::NumAxes-1:0][sucbc_pkg::CoordW-1:0] b_start_ff;
   logic signed [sucbc_pkg::ProdW-1:0]                   b_prod_ff [sucbc_pkg::NumAxes];
   logic signed [sucbc_pkg::ProdW-1:0]                   b_prod_in [sucbc_pkg::NumAxes];

   logic                                                 c_valid_ff;
   logic                                                 c_hit_ff;
   logic [sucbc_pkg::FracW-1:0]                          c_entry_ff;
   logic [sucbc_pkg::FracW-1:0]                          c_best_ff;
   logic [sucbc_pkg::NumAxes-1:0][sucbc_pkg::CoordW-1:0] c_point_ff;
   logic [sucbc_pkg::FracW-1:0]                          c_entry_in;
   logic [sucbc_pkg::FracW-1:0]                          c_best_in;
   logic [sucbc_pkg::NumAxes-1:0][sucbc_pkg::CoordW-1:0] c_point_in;

   logic c_stall;
   logic b_stall;
   logic a_stall;

   assign c_stall  = c_valid_ff && rsp_stall;
   assign b_stall  = b_valid_ff && c_stall;
   assign a_stall  = a_valid_ff && b_stall;
   assign in_stall = a_stall;

   // axes in order x, y, z against the running interval
   always_comb begin
      logic [sucbc_pkg::QuoW-1:0] lo;
      logic [sucbc_pkg::QuoW-1:0] hi;
      logic [sucbc_pkg::QuoW-1:0] qi;
      logic [sucbc_pkg::QuoW-1:0] qo;
      logic                       miss;
      lo   = '0;
      hi   = sucbc_pkg::QuoOne;
      miss = 1'b0;
      for (int a = 0; a < sucbc_pkg::NumAxes; a++) begin
         qi = in_item.ax[a].near.quo;
         qo = in_item.ax[a].far.quo;
         if (in_item.ax[a].parallel) begin
            miss = miss | in_item.ax[a].par_miss;
         end else begin
            if (in_item.ax[a].out_neg || qo < lo || qi > hi
                || (qi == hi && in_item.ax[a].near.rem != '0)) begin
               miss = 1'b1;
            end
            if (qi > lo) begin
               lo = qi;
            end
            if (qo < hi) begin
               hi = qo;
            end
         end
      end
      a_hit_in = !miss;
      a_lo_in  = lo;
   end

   always_comb begin
      logic signed [sucbc_pkg::QuoW-1:0] lo_s;
      lo_s = {1'b0, a_lo_ff};
      for (int a = 0; a < sucbc_pkg::NumAxes; a++) begin
         b_prod_in[a] = $signed(a_delta_ff[a]) * lo_s;
      end
   end

   always_comb begin
      logic signed [sucbc_pkg::ProdW-1:0] rnd;
      for (int a = 0; a < sucbc_pkg::NumAxes; a++) begin
         rnd           = b_prod_ff[a] + 43'sd32768;
         c_point_in[a] = b_hit_ff ? b_start_ff[a] + rnd[39:16] : '0;
      end
      c_entry_in = b_hit_ff ? b_lo_ff : '0;
      c_best_in  = (b_hit_ff && b_lo_ff < b_best_ff) ? b_lo_ff : b_best_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
         b_valid_ff <= 1'b0;
         c_valid_ff <= 1'b0;
      end else begin
         if (!a_stall) begin
            a_valid_ff <= in_valid;
         end
         if (!b_stall) begin
            b_valid_ff <= a_valid_ff;
         end
         if (!c_stall) begin
            c_valid_ff <= b_valid_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (!a_stall) begin
         a_hit_ff  <= a_hit_in;
         a_lo_ff   <= a_lo_in[sucbc_pkg::FracW-1:0];
         a_best_ff <= in_item.best;
         for (int a = 0; a < sucbc_pkg::NumAxes; a++) begin
            a_start_ff[a] <= in_item.ax[a].start;
            a_delta_ff[a] <= in_item.ax[a].delta;
         end
      end
      if (!b_stall) begin
         b_hit_ff   <= a_hit_ff;
         b_lo_ff    <= a_lo_ff;
         b_best_ff  <= a_best_ff;
         b_start_ff <= a_start_ff;
         for (int a = 0; a < sucbc_pkg::NumAxes; a++) begin
            b_prod_ff[a] <= b_prod_in[a];
         end
      end
      if (!c_stall) begin
         c_hit_ff   <= b_hit_ff;
         c_entry_ff <= c_entry_in;
         c_best_ff  <= c_best_in;
         c_point_ff <= c_point_in;
      end
   end

   assign rsp_valid          = c_valid_ff;
   assign rsp_hit            = c_hit_ff;
   assign rsp_point          = c_point_ff;
   assign rsp_entry_fraction = c_entry_ff;
   assign rsp_best_fraction  = c_best_ff;

endmodule

[rtl/core/segment_unit_box_clip.sv]
`timescale 1ns / 1ps
// top level: segment against unit voxel clip, prep stage, division cell row, clip stages
//
//   channel | ports                                  | moves
//   --------+----------------------------------------+-------------------------------
//   req     | req_valid, req_stall, req_<field>      | one voxel and segment item
//   rsp     | rsp_valid, rsp_stall, rsp_<field>      | one hit result item per item
//
// one item accepted per cycle while req_stall is low, one result per item
// the path is 1 prep stage, 18 division cells (one quotient bit each), 3 clip stages
// reset clears every stage valid; payload registers are not reset
// a stall holds only the stages that are full, so empty stages keep taking items
module segment_unit_box_clip (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_stall,
   input  logic signed [sucbc_pkg::BlockW-1:0] req_block_x,
   input  logic signed [sucbc_pkg::BlockW-1:0] req_block_y,
   input  logic signed [sucbc_pkg::BlockW-1:0] req_block_z,
   input  logic signed [sucbc_pkg::CoordW-1:0] req_start_x,
   input  logic signed [sucbc_pkg::CoordW-1:0] req_start_y,
   input  logic signed [sucbc_pkg::CoordW-1:0] req_start_z,
   input  logic signed [sucbc_pkg::CoordW-1:0] req_end_x,
   input  logic signed [sucbc_pkg::CoordW-1:0] req_end_y,
   input  logic signed [sucbc_pkg::CoordW-1:0] req_end_z,
   input  logic [sucbc_pkg::FracW-1:0]         req_best_fraction_in,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output logic                               rsp_hit,
   output logic signed [sucbc_pkg::CoordW-1:0] rsp_point_x,
   output logic signed [sucbc_pkg::CoordW-1:0] rsp_point_y,
   output logic signed [sucbc_pkg::CoordW-1:0] rsp_point_z,
   output logic [sucbc_pkg::FracW-1:0]         rsp_entry_fraction,
   output logic [sucbc_pkg::FracW-1:0]         rsp_best_fraction
);

   logic                link_valid [sucbc_pkg::DivSteps+1];
   logic                link_stall [sucbc_pkg::DivSteps+1];
   sucbc_pkg::item_type link_item  [sucbc_pkg::DivSteps+1];

   logic [sucbc_pkg::NumAxes-1:0][sucbc_pkg::CoordW-1:0] point;

   sucbc_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_stall  (req_stall),
      .block     ({req_block_z, req_block_y, req_block_x}),
      .start     ({req_start_z, req_start_y, req_start_x}),
      .stop      ({req_end_z, req_end_y, req_end_x}),
      .best      (req_best_fraction_in),
      .out_valid (link_valid[0]),
      .out_item  (link_item[0]),
      .out_stall (link_stall[0])
   );

   for (genvar k = 0; k < sucbc_pkg::DivSteps; k++) begin : g_cell
      sucbc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .in_valid  (link_valid[k]),
         .in_stall  (link_stall[k]),
         .in_item   (link_item[k]),
         .out_valid (link_valid[k+1]),
         .out_item  (link_item[k+1]),
         .out_stall (link_stall[k+1])
      );
   end

   sucbc_clip u_clip (
      .clock              (clock),
      .reset              (reset),
      .in_valid           (link_valid[sucbc_pkg::DivSteps]),
      .in_stall           (link_stall[sucbc_pkg::DivSteps]),
      .in_item            (link_item[sucbc_pkg::DivSteps]),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_hit            (rsp_hit),
      .rsp_point          (point),
      .rsp_entry_fraction (rsp_entry_fraction),
      .rsp_best_fraction  (rsp_best_fraction)
   );

   assign rsp_point_x = point[0];
   assign rsp_point_y = point[1];
   assign rsp_point_z = point[2];

endmodule

[rtl/core/sucbc_checker.sv]
`timescale 1ns / 1ps
// checker on the top level ports of the segment unit box clip, with its bind
module sucbc_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               rsp_valid,
   input logic                               rsp_stall,
   input logic                               rsp_hit,
   input logic signed [sucbc_pkg::CoordW-1:0] rsp_point_x,
   input logic signed [sucbc_pkg::CoordW-1:0] rsp_point_y,
   input logic signed [sucbc_pkg::CoordW-1:0] rsp_point_z,
   input logic [sucbc_pkg::FracW-1:0]         rsp_entry_fraction,
   input logic [sucbc_pkg::FracW-1:0]         rsp_best_fraction
);

   a_reset_empty : assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result valid after reset");

   a_miss_zero : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_hit |-> rsp_point_x == '0 && rsp_point_y == '0
                                && rsp_point_z == '0 && rsp_entry_fraction == '0)
      else $error("miss item with non-zero point or fraction");

   a_best_min : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> rsp_best_fraction <= rsp_entry_fraction)
      else $error("best fraction above entry fraction on a hit");

   a_entry_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_hit |-> rsp_entry_fraction <= 17'h10000)
      else $error("entry fraction above one");

   a_hold : assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_hit)
                                 && $stable(rsp_best_fraction))
      else $error("stalled result item changed");

endmodule

bind segment_unit_box_clip sucbc_checker u_sucbc_checker (.*);
